>>> rtl/core/dns_name_decompressor_macros.svh
// ----------------------------------------------------------------------------
// DNS name decompressor assertion macros
// Concurrent assertion wrappers shared by the decompressor RTL.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESSOR_MACROS_SVH
`define DNS_NAME_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DNSD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DNSD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/dnsd_pkg.sv
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared constants, command/status types and helpers of the DNS name
// decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

   localparam int MSG_DEPTH_DEF = 4096;
   localparam int NAME_MAX      = 255;
   localparam int NB_DEPTH      = NAME_MAX + 1;
   localparam int NB_AW         = $clog2(NB_DEPTH);
   localparam int PTR_W         = 14;

   // request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_DECOMP = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FORMAT = 2'd1;
   localparam logic [1:0] ST_TRUNC  = 2'd2;

   // label byte classes
   localparam logic [7:0] LABEL_MAX  = 8'd63;
   localparam logic [7:0] PTR_MIN    = 8'd192;
   localparam logic [7:0] PTR_MASK   = 8'h3f;
   localparam logic [7:0] HOPS_INIT  = 8'd255;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [1:0] {
      RD_NONE    = 2'd0,
      RD_CUR_ADV = 2'd1,
      RD_PTR2    = 2'd2,
      RD_TGT     = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_ZERO = 2'd0,
      WR_LEN  = 2'd1,
      WR_CHAR = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      RSP_PLAIN    = 2'd0,
      RSP_WALK     = 2'd1,
      RSP_NAMEBYTE = 2'd2
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         msg_wr;
      rd_sel_type   rd_sel;
      logic         nb_wr;
      wr_sel_type   wr_sel;
      logic         nb_rd;
      logic         rsp_en;
      rsp_kind_type rsp_kind;
      logic [1:0]   rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [7:0] lb;
      logic       via;
      logic       sz_zero;
      logic       pos_max;
      logic       tpos_max;
      logic       ioffs_end;
      logic       ioffs_ptr_bad;
      logic       offs_bad;
      logic       hops_last;
      logic       cnt_last;
      logic       rem_zero;
   } stat_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

>>> rtl/core/dns_name_decompressor.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor
// DNS message store with label walk, pointer following and name readback.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; each one gives
// exactly one result, shown for a single cycle with rsp_valid high. The
// receiver cannot stall, so sample the rsp_ ports whenever rsp_valid is set.
// A load (req_type 0) writes one byte and answers in the cycle after it is
// taken; a read (req_type 2) reads the name buffer when taken and answers from
// S_NBRD. A decompress (req_type 1) fetches and evaluates each label length
// byte and each character in turn, reads the second byte and the target byte
// of each compression pointer, and answers from S_DONE; an error ends the walk
// in the cycle the check fails. The message store has a single read port whose
// data is registered: each source byte is fetched in one state and evaluated
// in the next. busy is high for the whole walk. No clearing pass runs after
// reset: the store and the name buffer hold unknown data until written.
// MSG_DEPTH must be a power of two; store addresses wrap modulo the depth.
// ----------------------------------------------------------------------------
module dns_name_decompressor #(
   parameter int MSG_DEPTH = dnsd_pkg::MSG_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_addr,
   input  logic [7:0]  req_data_byte,
   input  logic [12:0] req_remaining,
   input  logic [12:0] req_msg_size,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_name_len,
   output logic [8:0]  rsp_consumed,
   output logic [7:0]  rsp_name_byte
);

   dnsd_pkg::cmd_type  cmd;
   dnsd_pkg::stat_type stat;

   // sequencer: decode requests, drive the walk one step at a time
   dnsd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .stat     (stat)
   );

   // storage, walk counters and the result registers
   dnsd_datapath #(
      .MSG_DEPTH (MSG_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_addr      (req_addr),
      .req_data_byte (req_data_byte),
      .req_remaining (req_remaining),
      .req_msg_size  (req_msg_size),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_name_len  (rsp_name_len),
      .rsp_consumed  (rsp_consumed),
      .rsp_name_byte (rsp_name_byte)
   );

endmodule

>>> rtl/core/dnsd_datapath.sv
// ----------------------------------------------------------------------------
// dnsd_datapath
// Message store, name buffer, walk registers and result registers.
// ----------------------------------------------------------------------------
module dnsd_datapath #(
   parameter int MSG_DEPTH = dnsd_pkg::MSG_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dnsd_pkg::cmd_type   cmd,
   output dnsd_pkg::stat_type  stat,
   input  logic [11:0]         req_addr,
   input  logic [7:0]          req_data_byte,
   input  logic [12:0]         req_remaining,
   input  logic [12:0]         req_msg_size,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_name_len,
   output logic [8:0]          rsp_consumed,
   output logic [7:0]          rsp_name_byte
);

   localparam int AW  = $clog2(MSG_DEPTH);
   localparam int PW  = dnsd_pkg::PTR_W;
   localparam int NAW = dnsd_pkg::NB_AW;

   logic [7:0] msg_mem  [MSG_DEPTH];
   logic [7:0] name_mem [dnsd_pkg::NB_DEPTH];

   logic [7:0]    msg_rdata_ff, nb_rdata_ff;
   logic [11:0]   start_ff, start_in;
   logic [12:0]   sz_ff, sz_in;
   logic [12:0]   msgsz_ff, msgsz_in;
   logic [8:0]    pos_ff, pos_in;
   logic [NAW-1:0] tpos_ff, tpos_in;
   logic [7:0]    hops_ff, hops_in;
   logic [PW-1:0] ioffs_ff, ioffs_in;
   logic          via_ff, via_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [5:0]    hi_ff, hi_in;
   logic          rd_ok_ff, rd_ok_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_len_ff, rsp_len_in;
   logic [8:0]    rsp_cons_ff, rsp_cons_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;

   logic [PW-1:0] sum_addr, load_addr, offs;
   logic [PW:0]   offs_inc, ioffs_inc;
   logic [AW-1:0] cur_addr, msg_raddr;
   logic          msg_rd_en;
   logic [7:0]    nb_wdata;

   // address generation, wrapped to the store depth
   always_comb begin
      sum_addr  = {2'b00, start_ff} + {5'd0, pos_ff};
      load_addr = {2'b00, req_addr};
      offs      = {hi_ff, msg_rdata_ff};
      offs_inc  = {1'b0, offs} + 15'd1;
      ioffs_inc = {1'b0, ioffs_ff} + 15'd1;
      cur_addr  = via_ff ? ioffs_ff[AW-1:0] : sum_addr[AW-1:0];
      msg_raddr = (cmd.rd_sel == dnsd_pkg::RD_TGT) ? offs[AW-1:0] : cur_addr;
      msg_rd_en = (cmd.rd_sel != dnsd_pkg::RD_NONE);
   end

   always_comb begin
      stat.lb            = msg_rdata_ff;
      stat.via           = via_ff;
      stat.sz_zero       = (sz_ff == 13'd0);
      stat.pos_max       = (pos_ff >= 9'(dnsd_pkg::NAME_MAX));
      stat.tpos_max      = (tpos_ff >= NAW'(dnsd_pkg::NAME_MAX));
      stat.ioffs_end     = (ioffs_ff >= {1'b0, msgsz_ff});
      stat.ioffs_ptr_bad = (ioffs_inc >= {2'b00, msgsz_ff});
      stat.offs_bad      = (offs_inc >= {2'b00, msgsz_ff});
      stat.hops_last     = (hops_ff == 8'd1);
      stat.cnt_last      = (cnt_ff == 6'd1);
      stat.rem_zero      = (req_remaining == 13'd0);
   end

   always_comb begin
      unique case (cmd.wr_sel)
         dnsd_pkg::WR_LEN:  nb_wdata = msg_rdata_ff;
         dnsd_pkg::WR_CHAR: nb_wdata = dnsd_pkg::fold_lower(msg_rdata_ff);
         default:           nb_wdata = 8'd0;
      endcase
   end

   // walk register updates
   always_comb begin
      start_in = start_ff;
      sz_in    = sz_ff;
      msgsz_in = msgsz_ff;
      pos_in   = pos_ff;
      tpos_in  = tpos_ff;
      hops_in  = hops_ff;
      ioffs_in = ioffs_ff;
      via_in   = via_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      rd_ok_in = rd_ok_ff;
      if (cmd.load_req) begin
         start_in = req_addr;
         sz_in    = req_remaining;
         msgsz_in = req_msg_size;
         pos_in   = 9'd0;
         tpos_in  = '0;
         hops_in  = dnsd_pkg::HOPS_INIT;
         via_in   = 1'b0;
      end
      unique case (cmd.rd_sel)
         dnsd_pkg::RD_CUR_ADV: begin
            if (via_ff) begin
               ioffs_in = ioffs_inc[PW-1:0];
            end else begin
               pos_in = pos_ff + 9'd1;
               sz_in  = sz_ff - 13'd1;
            end
         end
         dnsd_pkg::RD_PTR2: begin
            hi_in   = msg_rdata_ff[5:0] & dnsd_pkg::PTR_MASK[5:0];
            hops_in = hops_ff - 8'd1;
            if (!via_ff) begin
               pos_in = pos_ff + 9'd1;
               sz_in  = sz_ff - 13'd1;
            end
         end
         dnsd_pkg::RD_TGT: begin
            via_in   = 1'b1;
            ioffs_in = offs_inc[PW-1:0];
         end
         default: ;
      endcase
      if (cmd.nb_wr) begin
         tpos_in = tpos_ff + NAW'(1);
         if (cmd.wr_sel == dnsd_pkg::WR_LEN) begin
            cnt_in = msg_rdata_ff[5:0];
         end else if (cmd.wr_sel == dnsd_pkg::WR_CHAR) begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
      if (cmd.nb_rd) begin
         rd_ok_in = (req_addr[11:8] == 4'd0);
      end
   end

   // result fields
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_cons_in   = rsp_cons_ff;
      rsp_byte_in   = rsp_byte_ff;
      if (cmd.rsp_en) begin
         rsp_status_in = dnsd_pkg::ST_OK;
         rsp_len_in    = 8'd0;
         rsp_cons_in   = 9'd0;
         rsp_byte_in   = 8'd0;
         unique case (cmd.rsp_kind)
            dnsd_pkg::RSP_WALK: begin
               rsp_status_in = cmd.rsp_status;
               if (cmd.rsp_status == dnsd_pkg::ST_OK) begin
                  rsp_len_in  = tpos_ff;
                  rsp_cons_in = pos_ff;
               end
            end
            dnsd_pkg::RSP_NAMEBYTE: begin
               rsp_byte_in = rd_ok_ff ? nb_rdata_ff : 8'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      sz_ff         <= sz_in;
      msgsz_ff      <= msgsz_in;
      pos_ff        <= pos_in;
      tpos_ff       <= tpos_in;
      hops_ff       <= hops_in;
      ioffs_ff      <= ioffs_in;
      via_ff        <= via_in;
      cnt_ff        <= cnt_in;
      hi_ff         <= hi_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_cons_ff   <= rsp_cons_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   // message store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.msg_wr) begin
         msg_mem[load_addr[AW-1:0]] <= req_data_byte;
      end
      if (msg_rd_en) begin
         msg_rdata_ff <= msg_mem[msg_raddr];
      end
   end

   // name buffer
   always_ff @(posedge clock) begin
      if (cmd.nb_wr) begin
         name_mem[tpos_ff] <= nb_wdata;
      end
      if (cmd.nb_rd) begin
         nb_rdata_ff <= name_mem[req_addr[NAW-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_name_len  = rsp_len_ff;
   assign rsp_consumed  = rsp_cons_ff;
   assign rsp_name_byte = rsp_byte_ff;

endmodule

>>> rtl/core/dnsd_ctrl.sv
// ----------------------------------------------------------------------------
// dnsd_ctrl
// Request decode and label/pointer walk sequencer.
// ----------------------------------------------------------------------------
`include "dns_name_decompressor_macros.svh"

module dnsd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_type,
   output logic               busy,
   output dnsd_pkg::cmd_type  cmd,
   input  dnsd_pkg::stat_type stat
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LBL    = 9'b000000010,
      S_LBL_EV = 9'b000000100,
      S_PTR_EV = 9'b000001000,
      S_TGT_EV = 9'b000010000,
      S_CHR    = 9'b000100000,
      S_CHR_EV = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_NBRD   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      do_head;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      do_head  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_type)
                  dnsd_pkg::REQ_LOAD: begin
                     cmd.msg_wr   = 1'b1;
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_kind = dnsd_pkg::RSP_PLAIN;
                  end
                  dnsd_pkg::REQ_DECOMP: begin
                     cmd.load_req = 1'b1;
                     if (stat.rem_zero) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_kind   = dnsd_pkg::RSP_WALK;
                        cmd.rsp_status = dnsd_pkg::ST_TRUNC;
                     end else begin
                        state_in = S_LBL;
                     end
                  end
                  dnsd_pkg::REQ_READ: begin
                     cmd.nb_rd = 1'b1;
                     state_in  = S_NBRD;
                  end
                  default: begin
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_kind = dnsd_pkg::RSP_PLAIN;
                  end
               endcase
            end
         end
         S_LBL: begin
            if ((stat.via ? stat.ioffs_end : (stat.pos_max || stat.sz_zero)) ||
                stat.tpos_max) begin
               cmd.rsp_status = dnsd_pkg::ST_FORMAT;
            end else begin
               cmd.rd_sel = dnsd_pkg::RD_CUR_ADV;
               state_in   = S_LBL_EV;
            end
         end
         S_LBL_EV: begin
            if (stat.lb == 8'd0) begin
               cmd.nb_wr  = 1'b1;
               cmd.wr_sel = dnsd_pkg::WR_ZERO;
               state_in   = S_DONE;
            end else begin
               do_head = 1'b1;
            end
         end
         S_TGT_EV: begin
            do_head = 1'b1;
         end
         S_PTR_EV: begin
            if (stat.offs_bad) begin
               cmd.rsp_status = dnsd_pkg::ST_FORMAT;
            end else begin
               cmd.rd_sel = dnsd_pkg::RD_TGT;
               state_in   = S_TGT_EV;
            end
         end
         S_CHR: begin
            if (stat.via ? stat.ioffs_end : stat.pos_max) begin
               cmd.rsp_status = dnsd_pkg::ST_FORMAT;
            end else if (!stat.via && stat.sz_zero) begin
               cmd.rsp_status = dnsd_pkg::ST_TRUNC;
            end else if (stat.tpos_max) begin
               cmd.rsp_status = dnsd_pkg::ST_FORMAT;
            end else begin
               cmd.rd_sel = dnsd_pkg::RD_CUR_ADV;
               state_in   = S_CHR_EV;
            end
         end
         S_CHR_EV: begin
            cmd.nb_wr  = 1'b1;
            cmd.wr_sel = dnsd_pkg::WR_CHAR;
            state_in   = stat.cnt_last ? S_LBL : S_CHR;
         end
         S_DONE: begin
            cmd.rsp_en     = 1'b1;
            cmd.rsp_kind   = dnsd_pkg::RSP_WALK;
            cmd.rsp_status = dnsd_pkg::ST_OK;
            state_in       = S_IDLE;
         end
         S_NBRD: begin
            cmd.rsp_en   = 1'b1;
            cmd.rsp_kind = dnsd_pkg::RSP_NAMEBYTE;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // label head: length byte, reserved code or pointer
      if (do_head) begin
         if (stat.lb <= dnsd_pkg::LABEL_MAX) begin
            cmd.nb_wr  = 1'b1;
            cmd.wr_sel = dnsd_pkg::WR_LEN;
            state_in   = (stat.lb == 8'd0) ? S_LBL : S_CHR;
         end else if (stat.lb < dnsd_pkg::PTR_MIN) begin
            cmd.rsp_status = dnsd_pkg::ST_FORMAT;
         end else if (stat.via) begin
            if (stat.hops_last || stat.ioffs_ptr_bad) begin
               cmd.rsp_status = dnsd_pkg::ST_FORMAT;
            end else begin
               cmd.rd_sel = dnsd_pkg::RD_PTR2;
               state_in   = S_PTR_EV;
            end
         end else if (stat.sz_zero) begin
            cmd.rsp_status = dnsd_pkg::ST_TRUNC;
         end else if (stat.pos_max) begin
            cmd.rsp_status = dnsd_pkg::ST_FORMAT;
         end else begin
            cmd.rd_sel = dnsd_pkg::RD_PTR2;
            state_in   = S_PTR_EV;
         end
      end

      // any failed check ends the walk with an error result
      if (cmd.rsp_status != dnsd_pkg::ST_OK) begin
         cmd.rsp_en   = 1'b1;
         cmd.rsp_kind = dnsd_pkg::RSP_WALK;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `DNSD_ASSERT_IMP(a_nb_wr_room, clock, reset, cmd.nb_wr, !stat.tpos_max,
      "name buffer write past the name limit")
   `DNSD_ASSERT_NXT(a_rd_lands, clock, reset, cmd.rd_sel != dnsd_pkg::RD_NONE,
      (state_ff == S_LBL_EV || state_ff == S_CHR_EV || state_ff == S_PTR_EV ||
       state_ff == S_TGT_EV), "store read not followed by an evaluate state")
   `DNSD_ASSERT_IMP(a_end_rsp, clock, reset, (state_ff != S_IDLE && state_in == S_IDLE),
      cmd.rsp_en, "walk or read ended without a result")
   `DNSD_ASSERT_IMP(a_wr_idle, clock, reset, cmd.msg_wr, (state_ff == S_IDLE && start),
      "message store written outside an accepted load")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS name decompressor. Loads messages byte by
// byte, walks names through labels and compression pointers, and reads back
// the expanded name buffer. A built-in predictor mirrors the store, the name
// buffer and the label walk, and each rsp_ transaction is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ITEM_TARGET  = 1850;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int STORE_DEPTH  = dnsd_pkg::MSG_DEPTH_DEF;
   localparam int SITE_KEEP    = 48;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [12:0] rem;
      logic [12:0] msz;
   } dns_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] name_len;
      logic [8:0] consumed;
      logic [7:0] name_byte;
   } dns_ans_type;

   // start of a loaded name, with the bytes left up to the end of its message
   typedef struct {
      int start;
      int rem;
      int msz;
   } name_site_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = dnsd_pkg::REQ_LOAD;
   logic [11:0] req_addr = '0;
   logic [7:0]  req_data_byte = '0;
   logic [12:0] req_remaining = '0;
   logic [12:0] req_msg_size = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_name_len;
   logic [8:0]  rsp_consumed;
   logic [7:0]  rsp_name_byte;

   // predictor copy of the message store and of the name buffer
   logic [7:0] msg_image [0:STORE_DEPTH-1];
   bit         msg_written [0:STORE_DEPTH-1];
   logic [7:0] name_image [0:dnsd_pkg::NB_DEPTH-1];
   bit         name_written [0:dnsd_pkg::NB_DEPTH-1];

   dns_ans_type   expected_answers [$];
   dns_ans_type   oldest_ans;
   name_site_type name_sites [$];
   int            mismatches = 0;
   int            items_sent = 0;
   int            burst_left = 0;
   int            cycle_count = 0;

   dns_name_decompressor u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_addr      (req_addr),
      .req_data_byte (req_data_byte),
      .req_remaining (req_remaining),
      .req_msg_size  (req_msg_size),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_name_len  (rsp_name_len),
      .rsp_consumed  (rsp_consumed),
      .rsp_name_byte (rsp_name_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Fetch one store byte; flag the walk as unusable if the entry was never
   // loaded, since such a read is outside what the block guarantees.
   function automatic logic [7:0] fetch_msg_byte(input int a, inout bit clean);
      int idx;
      idx = a % STORE_DEPTH;
      if (!msg_written[idx]) clean = 1'b0;
      return msg_image[idx];
   endfunction

   function automatic void store_name_byte(input int idx, input logic [7:0] v,
                                           input bit commit);
      if (commit) begin
         name_image[idx]   = v;
         name_written[idx] = 1'b1;
      end
   endfunction

   // Walk the name at start: copy labels, fold upper case, follow pointers.
   // Name bytes land in the buffer only when commit is set; bytes written
   // before an error stay there, as on the block.
   function automatic logic [1:0] expand_name(input int start_ofs, input int rem,
                                              input int msz, input bit commit,
                                              output int len, output int cons,
                                              output bit clean);
      int pos, tpos, hops, ioffs, offs, sz, i;
      bit via, done;
      logic [7:0] lb, c;
      pos   = 0;
      tpos  = 0;
      hops  = int'(dnsd_pkg::HOPS_INIT);
      ioffs = 0;
      sz    = rem;
      via   = 1'b0;
      done  = 1'b0;
      len   = 0;
      cons  = 0;
      clean = 1'b1;
      if (sz == 0) return dnsd_pkg::ST_TRUNC;
      while (!done) begin
         if (via) begin
            if (ioffs >= msz) return dnsd_pkg::ST_FORMAT;
         end else begin
            if (pos >= dnsd_pkg::NAME_MAX || sz <= 0) return dnsd_pkg::ST_FORMAT;
         end
         if (tpos >= dnsd_pkg::NAME_MAX) return dnsd_pkg::ST_FORMAT;
         if (via) begin
            lb = fetch_msg_byte(ioffs, clean);
            ioffs++;
         end else begin
            lb = fetch_msg_byte(start_ofs + pos, clean);
            sz--;
            pos++;
         end
         if (lb == 8'd0) begin
            store_name_byte(tpos, 8'd0, commit);
            tpos++;
            done = 1'b1;
         end else begin
            // resolve pointers until a plain label length shows up
            do begin
               if (lb > dnsd_pkg::LABEL_MAX && lb < dnsd_pkg::PTR_MIN)
                  return dnsd_pkg::ST_FORMAT;
               if (lb >= dnsd_pkg::PTR_MIN) begin
                  hops--;
                  if (via) begin
                     if (hops <= 0) return dnsd_pkg::ST_FORMAT;
                     if (ioffs >= msz - 1) return dnsd_pkg::ST_FORMAT;
                     offs = int'(lb & dnsd_pkg::PTR_MASK) * 256
                            + int'(fetch_msg_byte(ioffs, clean));
                  end else begin
                     if (sz < 1) return dnsd_pkg::ST_TRUNC;
                     if (pos >= dnsd_pkg::NAME_MAX) return dnsd_pkg::ST_FORMAT;
                     offs = int'(lb & dnsd_pkg::PTR_MASK) * 256
                            + int'(fetch_msg_byte(start_ofs + pos, clean));
                     pos++;
                     sz--;
                  end
                  if (offs >= msz - 1) return dnsd_pkg::ST_FORMAT;
                  via   = 1'b1;
                  lb    = fetch_msg_byte(offs, clean);
                  ioffs = offs + 1;
               end
            end while (lb > dnsd_pkg::LABEL_MAX);
            store_name_byte(tpos, lb, commit);
            tpos++;
            for (i = 0; i < int'(lb); i++) begin
               if (via) begin
                  if (ioffs >= msz) return dnsd_pkg::ST_FORMAT;
               end else begin
                  if (pos >= dnsd_pkg::NAME_MAX) return dnsd_pkg::ST_FORMAT;
                  if (sz <= 0) return dnsd_pkg::ST_TRUNC;
               end
               if (tpos >= dnsd_pkg::NAME_MAX) return dnsd_pkg::ST_FORMAT;
               c = via ? fetch_msg_byte(ioffs, clean)
                       : fetch_msg_byte(start_ofs + pos, clean);
               if (c >= dnsd_pkg::CHAR_UPPER_A && c <= dnsd_pkg::CHAR_UPPER_Z)
                  c = c + dnsd_pkg::CASE_OFFSET;
               store_name_byte(tpos, c, commit);
               tpos++;
               if (via) begin
                  ioffs++;
               end else begin
                  pos++;
                  sz--;
               end
            end
         end
      end
      len  = tpos;
      cons = pos;
      return dnsd_pkg::ST_OK;
   endfunction

   // Work out the answer to one request; return 0 if the request would read
   // a store or name buffer entry that was never written. State changes only with commit.
   function automatic bit predict_answer(input dns_req_type rq, input bit commit,
                                         output dns_ans_type ans);
      int len, cons, idx;
      bit clean;
      ans   = '0;
      clean = 1'b1;
      case (rq.kind)
         dnsd_pkg::REQ_LOAD: begin
            if (commit) begin
               msg_image[rq.addr]   = rq.data;
               msg_written[rq.addr] = 1'b1;
            end
         end
         dnsd_pkg::REQ_DECOMP: begin
            ans.status = expand_name(int'(rq.addr), int'(rq.rem), int'(rq.msz), commit,
                                     len, cons, clean);
            if (ans.status == dnsd_pkg::ST_OK) begin
               ans.name_len = 8'(len);
               ans.consumed = 9'(cons);
            end
         end
         dnsd_pkg::REQ_READ: begin
            idx = int'(rq.addr);
            if (idx < dnsd_pkg::NB_DEPTH) begin
               clean         = name_written[idx];
               ans.name_byte = name_image[idx];
            end
         end
         default: ;
      endcase
      return clean;
   endfunction

   // -------------------------------------------------------------------------
   // Result checker: the receiver cannot stall, so take every strobe.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("rsp transaction with nothing expected");
            mismatches++;
         end else begin
            oldest_ans = expected_answers.pop_front();
            if (rsp_status !== oldest_ans.status) begin
               $error("status: expected %0d, got %0d", oldest_ans.status, rsp_status);
               mismatches++;
            end
            if (rsp_name_len !== oldest_ans.name_len) begin
               $error("name_len: expected %0d, got %0d", oldest_ans.name_len, rsp_name_len);
               mismatches++;
            end
            if (rsp_consumed !== oldest_ans.consumed) begin
               $error("consumed: expected %0d, got %0d", oldest_ans.consumed, rsp_consumed);
               mismatches++;
            end
            if (rsp_name_byte !== oldest_ans.name_byte) begin
               $error("name_byte: expected %0d, got %0d",
                      oldest_ans.name_byte, rsp_name_byte);
               mismatches++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Send one transaction and record its answer once taken. Drop requests
   // that would touch unwritten store or name buffer entries. Called right
   // after a rising edge; leave start high so the next transaction can follow
   // back to back.
   task automatic send_request(input dns_req_type rq, output bit sent);
      dns_ans_type ans;
      int gap;
      sent = predict_answer(rq, 1'b0, ans);
      if (!sent) return;
      // idle between bursts; some bursts run with no gap at all
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start         <= 1'b1;
      req_type      <= rq.kind;
      req_addr      <= rq.addr;
      req_data_byte <= rq.data;
      req_remaining <= rq.rem;
      req_msg_size  <= rq.msz;
      // taken at the first edge that sees busy low
      do @(posedge clock); while (busy);
      void'(predict_answer(rq, 1'b1, ans));
      expected_answers.push_back(ans);
      items_sent++;
   endtask

   task automatic load_byte(input int addr, input logic [7:0] data);
      dns_req_type rq;
      bit sent;
      rq.kind = dnsd_pkg::REQ_LOAD;
      rq.addr = 12'(addr % STORE_DEPTH);
      rq.data = data;
      rq.rem  = 13'($urandom_range(0, 4096));
      rq.msz  = 13'($urandom_range(0, 4096));
      send_request(rq, sent);
   endtask

   task automatic decompress_at(input int start_ofs, input int rem, input int msz,
                                output bit sent);
      dns_req_type rq;
      rq.kind = dnsd_pkg::REQ_DECOMP;
      rq.addr = 12'(start_ofs);
      rq.data = 8'($urandom_range(0, 255));
      rq.rem  = 13'(rem);
      rq.msz  = 13'(msz);
      send_request(rq, sent);
   endtask

   task automatic read_name(input int idx, output bit sent);
      dns_req_type rq;
      rq.kind = dnsd_pkg::REQ_READ;
      rq.addr = 12'(idx);
      rq.data = 8'($urandom_range(0, 255));
      rq.rem  = 13'($urandom_range(0, 4096));
      rq.msz  = 13'($urandom_range(0, 4096));
      send_request(rq, sent);
   endtask

   // -------------------------------------------------------------------------
   // Directed tests
   // -------------------------------------------------------------------------

   // Label copy across the store wrap, case folding at the letter edges,
   // truncation inside a label, empty source, readback of the name buffer.
   task automatic test_label_copy();
      bit sent;
      load_byte(4093, 8'd4);
      load_byte(4094, dnsd_pkg::CHAR_UPPER_A);
      load_byte(4095, dnsd_pkg::CHAR_UPPER_Z);
      load_byte(0, dnsd_pkg::CHAR_UPPER_A - 8'd1);
      load_byte(1, dnsd_pkg::CHAR_UPPER_Z + 8'd1);
      load_byte(2, 8'd0);
      decompress_at(4093, 4096, 4096, sent);
      decompress_at(4093, 3, 4096, sent);
      decompress_at(4093, 0, 4096, sent);
      read_name(1, sent);
      read_name(4, sent);
      read_name(4095, sent);
   endtask

   // Pointer to the name above, then the same with a cut source, a zero
   // message size, and a target right at the pointer bound.
   task automatic test_pointers();
      bit sent;
      load_byte(3, dnsd_pkg::PTR_MIN | 8'h0f);
      load_byte(4, 8'hfd);
      decompress_at(3, 2, 4096, sent);
      decompress_at(3, 1, 4096, sent);
      decompress_at(3, 2, 0, sent);
      decompress_at(3, 2, 4094, sent);
   endtask

   // Out-of-range pointer built from all-ones bytes, reserved label code.
   task automatic test_bad_labels();
      bit sent;
      load_byte(8, 8'hff);
      load_byte(9, 8'hff);
      load_byte(10, dnsd_pkg::LABEL_MAX + 8'd1);
      decompress_at(8, 2, 4096, sent);
      decompress_at(10, 1, 4096, sent);
   endtask

   // Pointer to itself: spins until the hop budget runs out.
   task automatic test_hop_limit();
      bit sent;
      load_byte(6, dnsd_pkg::PTR_MIN);
      load_byte(7, 8'd6);
      decompress_at(6, 2, 4096, sent);
   endtask

   // -------------------------------------------------------------------------
   // Random traffic
   // -------------------------------------------------------------------------

   // Build a message of a few names with random labels, back references and
   // the odd self loop or reserved label byte, load it, and note its names.
   task automatic build_message();
      logic [7:0] msg_bytes [$];
      int starts [$];
      int base, nnames, nlabels, llen, k, j, m, target, msz, total;
      logic [7:0] c;
      name_site_type site;
      base   = $urandom_range(0, 3900);
      nnames = $urandom_range(1, 4);
      for (k = 0; k < nnames; k++) begin
         starts.push_back(base + msg_bytes.size());
         nlabels = $urandom_range(0, 3);
         for (j = 0; j < nlabels; j++) begin
            llen = ($urandom_range(0, 19) == 0) ? int'(dnsd_pkg::LABEL_MAX)
                                                : $urandom_range(1, 9);
            if ($urandom_range(0, 29) == 0)
               msg_bytes.push_back(8'($urandom_range(int'(dnsd_pkg::LABEL_MAX) + 1,
                                                     int'(dnsd_pkg::PTR_MIN) - 1)));
            else
               msg_bytes.push_back(8'(llen));
            for (m = 0; m < llen; m++) begin
               case ($urandom_range(0, 4))
                  0, 1: c = dnsd_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
                  2: c = dnsd_pkg::CHAR_UPPER_A + dnsd_pkg::CASE_OFFSET
                         + 8'($urandom_range(0, 25));
                  3: c = 8'h2d + 8'($urandom_range(0, 12));
                  default: c = 8'($urandom_range(0, 255));
               endcase
               msg_bytes.push_back(c);
            end
         end
         // end the name: zero label, back reference, or a loop to itself
         case ($urandom_range(0, 9))
            0: target = starts[k] % STORE_DEPTH;
            1, 2, 3, 4: target = (k > 0) ? starts[$urandom_range(0, k - 1)] % STORE_DEPTH : -1;
            default: target = -1;
         endcase
         if (target < 0) begin
            msg_bytes.push_back(8'd0);
         end else begin
            msg_bytes.push_back(dnsd_pkg::PTR_MIN | 8'(target >> 8));
            msg_bytes.push_back(8'(target));
         end
      end
      total = msg_bytes.size();
      msz = base + total + $urandom_range(0, 2);
      if (msz > STORE_DEPTH) msz = STORE_DEPTH;
      for (m = 0; m < total; m++) load_byte(base + m, msg_bytes[m]);
      for (k = 0; k < nnames; k++) begin
         site.start = starts[k] % STORE_DEPTH;
         site.rem   = base + total - starts[k];
         site.msz   = msz;
         name_sites.push_back(site);
         if (name_sites.size() > SITE_KEEP) void'(name_sites.pop_front());
      end
   endtask

   // Mostly well-formed walks of loaded names, some cut short or with a
   // wrong message size, plus walks from arbitrary offsets; readback of the
   // name buffer; stray loads that corrupt loaded messages.
   task automatic test_random_traffic();
      name_site_type site;
      int r, tries, st, rem, msz, idx;
      bit sent;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (name_sites.size() == 0 || r < 3) begin
            build_message();
         end else if (r < 68) begin
            sent = 1'b0;
            for (tries = 0; tries < 4 && !sent; tries++) begin
               site = name_sites[$urandom_range(0, name_sites.size() - 1)];
               st   = site.start;
               rem  = site.rem;
               msz  = site.msz;
               if ($urandom_range(0, 4) == 0) begin
                  st  = ($urandom_range(0, 1) == 0) ? (st + $urandom_range(0, 16)) % STORE_DEPTH
                                                    : $urandom_range(0, STORE_DEPTH - 1);
                  rem = $urandom_range(0, 4096);
                  msz = $urandom_range(0, 4096);
               end else begin
                  case ($urandom_range(0, 9))
                     0: rem = $urandom_range(0, site.rem);
                     1: rem = $urandom_range(site.rem, 4096);
                     2: msz = $urandom_range(0, 4096);
                     default: ;
                  endcase
               end
               decompress_at(st, rem, msz, sent);
            end
         end else if (r < 88) begin
            sent = 1'b0;
            for (tries = 0; tries < 16 && !sent; tries++) begin
               idx = ($urandom_range(0, 4) == 0)
                     ? $urandom_range(dnsd_pkg::NB_DEPTH, STORE_DEPTH - 1)
                     : $urandom_range(0, dnsd_pkg::NB_DEPTH - 1);
               read_name(idx, sent);
            end
         end else begin
            site = name_sites[$urandom_range(0, name_sites.size() - 1)];
            idx  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, STORE_DEPTH - 1)
                                               : site.start + $urandom_range(0, 10);
            load_byte(idx, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // hold reset, then release it on an edge
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_label_copy();
      test_pointers();
      test_bad_labels();
      test_hop_limit();
      test_random_traffic();
      start <= 1'b0;
      // drain outstanding answers, then let the block settle
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/dnsd_pkg.sv
rtl/core/dnsd_datapath.sv
rtl/core/dnsd_ctrl.sv
rtl/core/dns_name_decompressor.sv
bench/tb_top.sv
